@@ hdl/mtb_pkg.sv @@
package mtb_pkg;

  // field widths
  localparam int OP_W     = 3;
  localparam int ID_W     = 4;
  localparam int TOKEN_W  = 16;
  // slots that a 4-bit bucket_id can name
  localparam int ID_SLOTS = 16;

  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 3'd0,
    OP_ALLOC = 3'd1,
    OP_GET   = 3'd2,
    OP_PUT   = 3'd3,
    OP_FREE  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_UNALLOC = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_e;

  // one request as the core sees it
  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [ID_W-1:0]    bucket;
    logic [TOKEN_W-1:0] amount;
    logic [TOKEN_W-1:0] rate;
    logic [TOKEN_W-1:0] burst_limit;
  } cmd_t;

  // one result item
  typedef struct packed {
    status_e            status;
    logic [ID_W-1:0]    bucket_id;
    logic [TOKEN_W-1:0] granted;
  } res_t;

  // add with saturation at the bucket cap
  function automatic logic [TOKEN_W-1:0] clamp_add(input logic [TOKEN_W-1:0] base,
                                                   input logic [TOKEN_W-1:0] add,
                                                   input logic [TOKEN_W-1:0] cap);
    logic [TOKEN_W:0] sum;
    sum = {1'b0, base} + {1'b0, add};
    return (sum >= {1'b0, cap}) ? cap : sum[TOKEN_W-1:0];
  endfunction

endpackage

@@ hdl/mtb_req_if.sv @@
interface mtb_req_if import mtb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [ID_W-1:0]    bucket;
  logic [TOKEN_W-1:0] amount;
  logic [TOKEN_W-1:0] rate;
  logic [TOKEN_W-1:0] burst_limit;

  modport source (output valid, op, bucket, amount, rate, burst_limit, input ready);
  modport sink   (input valid, op, bucket, amount, rate, burst_limit, output ready);
endinterface

@@ hdl/mtb_rsp_if.sv @@
interface mtb_rsp_if import mtb_pkg::*; ();
  logic               valid;
  logic               ready;
  status_e            status;
  logic [ID_W-1:0]    bucket_id;
  logic [TOKEN_W-1:0] granted;

  modport source (output valid, status, bucket_id, granted, input ready);
  modport sink   (input valid, status, bucket_id, granted, output ready);
endinterface

@@ hdl/mtb_core.sv @@
module mtb_core import mtb_pkg::*; #(
  parameter int BUCKETS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  cmd_t cmd_i,
  output logic idle_o,
  output logic res_valid_o,
  input  logic res_take_i,
  output res_t res_o
);

  localparam int AW   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int SCAN = (BUCKETS < ID_SLOTS) ? BUCKETS : ID_SLOTS;
  localparam logic [AW-1:0] LAST      = AW'(BUCKETS - 1);
  localparam logic [AW-1:0] SCAN_LAST = AW'(SCAN - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_TICK,
    S_ALLOC,
    S_ACCESS,
    S_DONE
  } state_e;

  typedef struct packed {
    logic               valid;
    logic [TOKEN_W-1:0] count;
  } cnt_ent_t;

  typedef struct packed {
    logic [TOKEN_W-1:0] rate;
    logic [TOKEN_W-1:0] cap;
  } shp_ent_t;

  // slot state memories: valid/count is cleared after reset, rate/cap is not
  cnt_ent_t cnt_mem [BUCKETS];
  shp_ent_t shp_mem [BUCKETS];
  cnt_ent_t cnt_rd_q;
  shp_ent_t shp_rd_q;

  state_e         state_q, state_d;
  logic [AW-1:0]  addr_q, addr_d;
  cmd_t           cmd_q, cmd_d;
  res_t           res_q, res_d;
  logic           in_range_q, in_range_d;

  logic [AW-1:0]  raddr;
  logic           cnt_we, shp_we;
  cnt_ent_t       cnt_wdata;
  shp_ent_t       shp_wdata;
  logic           live;
  logic [TOKEN_W-1:0] grant;

  // read address: first entry when a scan starts, the next entry during a scan, the addressed bucket otherwise
  always_comb begin
    case (state_q)
      S_IDLE: begin
        if (cmd_i.op == OP_TICK || cmd_i.op == OP_ALLOC) begin
          raddr = '0;
        end else begin
          raddr = AW'(cmd_i.bucket);
        end
      end
      S_TICK, S_ALLOC: raddr = addr_q + AW'(1);
      default:         raddr = addr_q;
    endcase
  end

  assign live  = in_range_q && cnt_rd_q.valid;
  assign grant = (cmd_q.amount < cnt_rd_q.count) ? cmd_q.amount : cnt_rd_q.count;

  // sequencer: read, modify, write back
  always_comb begin
    state_d    = state_q;
    addr_d     = addr_q;
    cmd_d      = cmd_q;
    res_d      = res_q;
    in_range_d = in_range_q;
    cnt_we     = 1'b0;
    cnt_wdata  = '0;
    shp_we     = 1'b0;
    shp_wdata  = '{rate: cmd_q.rate, cap: cmd_q.burst_limit};
    case (state_q)
      S_CLEAR: begin
        cnt_we = 1'b1;
        addr_d = addr_q + AW'(1);
        if (addr_q == LAST) begin
          addr_d  = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_d      = cmd_i;
          in_range_d = int'(cmd_i.bucket) < BUCKETS;
          addr_d     = raddr;
          case (cmd_i.op)
            OP_TICK:                state_d = S_TICK;
            OP_ALLOC:               state_d = S_ALLOC;
            OP_GET, OP_PUT, OP_FREE: state_d = S_ACCESS;
            default: begin
              res_d   = '{status: ST_OK, bucket_id: cmd_i.bucket, granted: '0};
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_TICK: begin
        if (cnt_rd_q.valid) begin
          cnt_we    = 1'b1;
          cnt_wdata = '{valid: 1'b1,
                        count: clamp_add(cnt_rd_q.count, shp_rd_q.rate, shp_rd_q.cap)};
        end
        if (addr_q == LAST) begin
          res_d   = '{status: ST_OK, bucket_id: '0, granted: '0};
          state_d = S_DONE;
        end else begin
          addr_d = raddr;
        end
      end
      S_ALLOC: begin
        if (!cnt_rd_q.valid) begin
          cnt_we    = 1'b1;
          cnt_wdata = '{valid: 1'b1, count: '0};
          shp_we    = 1'b1;
          res_d     = '{status: ST_OK, bucket_id: ID_W'(addr_q), granted: '0};
          state_d   = S_DONE;
        end else if (addr_q == SCAN_LAST) begin
          res_d   = '{status: ST_FULL, bucket_id: '0, granted: '0};
          state_d = S_DONE;
        end else begin
          addr_d = raddr;
        end
      end
      S_ACCESS: begin
        res_d   = '{status: ST_OK, bucket_id: cmd_q.bucket, granted: '0};
        state_d = S_DONE;
        if (!live) begin
          res_d.status = ST_UNALLOC;
        end else begin
          case (cmd_q.op)
            OP_GET: begin
              if (cnt_rd_q.count == '0) begin
                res_d.status = ST_EMPTY;
              end else begin
                res_d.granted = grant;
                cnt_we        = 1'b1;
                cnt_wdata     = '{valid: 1'b1, count: cnt_rd_q.count - grant};
              end
            end
            OP_PUT: begin
              cnt_we    = 1'b1;
              cnt_wdata = '{valid: 1'b1,
                            count: clamp_add(cnt_rd_q.count, cmd_q.amount, shp_rd_q.cap)};
            end
            OP_FREE: begin
              cnt_we    = 1'b1;
              cnt_wdata = '{valid: 1'b0, count: '0};
            end
            default: cnt_we = 1'b0;
          endcase
        end
      end
      S_DONE: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      addr_q     <= '0;
      in_range_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      addr_q     <= addr_d;
      in_range_q <= in_range_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    res_q <= res_d;
  end

  // memory ports, registered read
  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[addr_q] <= cnt_wdata;
    end
    if (shp_we) begin
      shp_mem[addr_q] <= shp_wdata;
    end
    cnt_rd_q <= cnt_mem[raddr];
    shp_rd_q <= shp_mem[raddr];
  end

  assign idle_o      = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

endmodule

@@ hdl/multi_token_bucket_table_unit.sv @@
// Table of BUCKETS token buckets behind a request channel (req_i) and a
// result channel (rsp_o), both valid/ready; a transfer happens when valid and
// ready are high at a rising edge. Every request gives exactly one result.
// Operations: tick refills all valid buckets, allocate claims the lowest free
// slot, get/put move tokens, free releases a slot.
// One request is in work at a time; req_i.ready is high while the sequencer
// is idle. Tick does one memory read-modify-write per slot, allocate scans
// the valid bits of up to min(BUCKETS, 16) slots, get, put and free do one
// read-modify-write, and an unknown op gives an ok result with no memory access.
// The next request is taken in the cycle the result is shown.
// After reset a clearing pass over all BUCKETS slots zeroes valid bits and counts;
// req_i.ready stays low until it ends.
// A stalled result waits in the output register; the sequencer takes the
// next request meanwhile and holds its own result until the register frees.
module multi_token_bucket_table_unit import mtb_pkg::*; #(
  parameter int BUCKETS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mtb_req_if.sink   req_i,
  mtb_rsp_if.source rsp_o
);

  cmd_t core_cmd;
  res_t core_res;
  logic core_idle;
  logic core_res_valid;
  logic res_take;
  logic out_valid_q, out_valid_d;
  res_t out_q;

  assign core_cmd = '{op:          req_i.op,
                      bucket:      req_i.bucket,
                      amount:      req_i.amount,
                      rate:        req_i.rate,
                      burst_limit: req_i.burst_limit};

  assign req_i.ready = core_idle;

  mtb_core #(
    .BUCKETS(BUCKETS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (req_i.valid && core_idle),
    .cmd_i      (core_cmd),
    .idle_o     (core_idle),
    .res_valid_o(core_res_valid),
    .res_take_i (res_take),
    .res_o      (core_res)
  );

  // output register, loads when empty or being drained
  assign res_take = core_res_valid && (!out_valid_q || rsp_o.ready);

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_take) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= core_res;
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.status    = out_q.status;
  assign rsp_o.bucket_id = out_q.bucket_id;
  assign rsp_o.granted   = out_q.granted;

endmodule

@@ hdl/mtb_checker.sv @@
module mtb_checker import mtb_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               req_valid_i,
  input logic               req_ready_i,
  input logic               rsp_valid_i,
  input logic               rsp_ready_i,
  input status_e            rsp_status_i,
  input logic [ID_W-1:0]    rsp_bucket_id_i,
  input logic [TOKEN_W-1:0] rsp_granted_i
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i)
      && $stable(rsp_bucket_id_i) && $stable(rsp_granted_i))
    else $error("stalled result changed");

  // one request in work at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while busy");

  // no request taken during reset or the first clearing cycle
  assert property (@(posedge clk_i) !$past(rst_ni) |-> !req_ready_i)
    else $error("ready during clearing pass");

  // tokens are only granted with ok status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_granted_i != '0 |-> rsp_status_i == ST_OK)
    else $error("grant with error status");

endmodule

bind multi_token_bucket_table_unit mtb_checker u_mtb_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid_i    (req_i.valid),
  .req_ready_i    (req_i.ready),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .rsp_status_i   (rsp_o.status),
  .rsp_bucket_id_i(rsp_o.bucket_id),
  .rsp_granted_i  (rsp_o.granted)
);
